@@ hw/rtl/tccw_pkg.sv @@
// Package for the text console character writer: field widths, character codes,
// state machine type and the command and status structs between controller and datapath.
// Depends on nothing.
package tccw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam int FUNC_WIDTH   = 1;
   localparam int CHAR_WIDTH   = 8;
   localparam int INDEX_WIDTH  = 11;
   localparam int VALUE_WIDTH  = 16;
   localparam int COLUMN_WIDTH = 7;
   localparam int ROW_WIDTH    = 5;

   localparam logic [CHAR_WIDTH-1:0] NULL_CHAR      = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] NEWLINE_CHAR   = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] SPACE_CHAR     = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CELL_ATTRIBUTE = 8'h07;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_PUT  = 1'b0,
      FUNC_READ = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic put;
      logic read;
      logic load_read;
      logic sweep;
   } cmd_type;

   typedef struct packed {
      logic put_clears;
      logic sweep_last;
   } status_type;

endpackage

@@ hw/rtl/tccw_ctrl.sv @@
// Controller for the text console character writer: sequences puts, reads and
// screen sweeps and owns both handshakes. Depends on tccw_pkg.
module tccw_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic [tccw_pkg::FUNC_WIDTH-1:0]      req_func,
   output logic                                 req_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  tccw_pkg::status_type                 status,
   output tccw_pkg::cmd_type                    cmd
);
   import tccw_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      is_read;

   assign is_read = (req_func == FUNC_READ);
   assign accept  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_read) begin
                  state_in = ST_READ;
               end else if (status.put_clears) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.put       = 1'b0;
      cmd.read      = 1'b0;
      cmd.load_read = 1'b0;
      cmd.sweep     = 1'b0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            cmd.put   = req_valid && req_ready && !is_read;
            cmd.read  = req_valid && req_ready && is_read;
         end
         ST_READ: begin
            cmd.load_read = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.put || cmd.load_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/tccw_dp.sv @@
// Datapath for the text console character writer: cursor and linear address
// registers, the character memory with its sweep counter, and the result register.
// Depends on tccw_pkg.
module tccw_dp #(
   parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tccw_pkg::cmd_type                    cmd,
   input  logic [tccw_pkg::CHAR_WIDTH-1:0]      req_character,
   input  logic [tccw_pkg::INDEX_WIDTH-1:0]     req_cell_index,
   output tccw_pkg::status_type                 status,
   output logic [tccw_pkg::VALUE_WIDTH-1:0]     rsp_cell_value,
   output logic [tccw_pkg::COLUMN_WIDTH-1:0]    rsp_cursor_column,
   output logic [tccw_pkg::ROW_WIDTH-1:0]       rsp_cursor_row,
   output logic                                 rsp_screen_cleared
);
   import tccw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   logic [CHAR_WIDTH-1:0]   char_mem_ff [CELL_COUNT];
   logic [CHAR_WIDTH-1:0]   rd_char_ff;
   logic                    in_range_ff;

   logic [COL_W-1:0]        col_ff;
   logic [COL_W-1:0]        col_in;
   logic [ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]        row_in;
   logic [ADDR_W-1:0]       addr_ff;
   logic [ADDR_W-1:0]       addr_in;
   logic [ADDR_W-1:0]       sweep_ff;
   logic [ADDR_W-1:0]       sweep_in;

   logic [VALUE_WIDTH-1:0]  value_ff;
   logic [COLUMN_WIDTH-1:0] column_ff;
   logic [ROW_WIDTH-1:0]    row_out_ff;
   logic                    cleared_ff;

   logic [COL_W:0]          col_inc;
   logic [ROW_W:0]          row_inc;
   logic                    is_newline;
   logic                    is_print;
   logic                    row_advance;
   logic                    put_clears;
   logic                    sweep_last;
   logic [ADDR_W-1:0]       rd_addr;

   assign is_newline  = (req_character == NEWLINE_CHAR);
   assign is_print    = (req_character != NULL_CHAR) && !is_newline;
   assign col_inc     = {1'b0, col_ff} + (COL_W + 1)'(1);
   assign row_inc     = {1'b0, row_ff} + (ROW_W + 1)'(1);
   assign row_advance = is_newline || (is_print && (col_inc == (COL_W + 1)'(COLUMNS)));
   assign put_clears  = row_advance && (row_inc == (ROW_W + 1)'(ROWS));
   assign sweep_last  = (sweep_ff == ADDR_W'(CELL_COUNT - 1));
   assign rd_addr     = ADDR_W'(req_cell_index);

   assign status.put_clears = put_clears;
   assign status.sweep_last = sweep_last;

   // The linear address tracks row * COLUMNS + column so no multiply is needed.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      addr_in = addr_ff;
      if (put_clears) begin
         col_in  = '0;
         row_in  = '0;
         addr_in = '0;
      end else if (row_advance) begin
         col_in = '0;
         row_in = row_inc[ROW_W-1:0];
         if (is_newline) begin
            addr_in = addr_ff - ADDR_W'(col_ff) + ADDR_W'(COLUMNS);
         end else begin
            addr_in = addr_ff + ADDR_W'(1);
         end
      end else if (is_print) begin
         col_in  = col_inc[COL_W-1:0];
         addr_in = addr_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep) begin
         sweep_in = sweep_last ? '0 : sweep_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         addr_ff  <= '0;
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
         if (cmd.put) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            addr_ff <= addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         char_mem_ff[sweep_ff] <= SPACE_CHAR;
      end else if (cmd.put && is_print) begin
         char_mem_ff[addr_ff] <= req_character;
      end
      if (cmd.read) begin
         rd_char_ff  <= char_mem_ff[rd_addr];
         in_range_ff <= (int'(req_cell_index) < CELL_COUNT);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         value_ff   <= '0;
         column_ff  <= COLUMN_WIDTH'(col_in);
         row_out_ff <= ROW_WIDTH'(row_in);
         cleared_ff <= put_clears;
      end else if (cmd.load_read) begin
         value_ff   <= in_range_ff ? {CELL_ATTRIBUTE, rd_char_ff} : '0;
         column_ff  <= COLUMN_WIDTH'(col_ff);
         row_out_ff <= ROW_WIDTH'(row_ff);
         cleared_ff <= 1'b0;
      end
   end

   assign rsp_cell_value     = value_ff;
   assign rsp_cursor_column  = column_ff;
   assign rsp_cursor_row     = row_out_ff;
   assign rsp_screen_cleared = cleared_ff;

endmodule

@@ hw/rtl/text_console_character_writer.sv @@
// Top level of the text console character writer: joins the controller and the datapath.
// Depends on tccw_pkg, tccw_ctrl and tccw_dp.
//
//   Channel   Handshake               Payload
//   req       req_valid / req_ready   req_func, req_character, req_cell_index
//   rsp       rsp_valid / rsp_ready   rsp_cell_value, rsp_cursor_column, rsp_cursor_row,
//                                     rsp_screen_cleared
//
// A put loads the result register as it is accepted; a read first passes through the
// registered read of the character memory (ST_READ) before the result register is loaded.
// Reset starts a sweep that writes a space to every cell,
// with req_ready low throughout.
// A put that runs past the bottom row starts the same sweep; its result is offered at once.
// req_ready is also low while the result register holds a transaction not yet taken.
module text_console_character_writer #(
   parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tccw_pkg::FUNC_WIDTH-1:0]      req_func,
   input  logic [tccw_pkg::CHAR_WIDTH-1:0]      req_character,
   input  logic [tccw_pkg::INDEX_WIDTH-1:0]     req_cell_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tccw_pkg::VALUE_WIDTH-1:0]     rsp_cell_value,
   output logic [tccw_pkg::COLUMN_WIDTH-1:0]    rsp_cursor_column,
   output logic [tccw_pkg::ROW_WIDTH-1:0]       rsp_cursor_row,
   output logic                                 rsp_screen_cleared
);
   import tccw_pkg::*;

   cmd_type    cmd;
   status_type status;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_character      (req_character),
      .req_cell_index     (req_cell_index),
      .status             (status),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_screen_cleared (rsp_screen_cleared)
   );

endmodule

@@ sim/tb_text_console_character_writer.sv @@
// Testbench for the text console character writer: drives put and read transactions
// with random idling on both channels; checks every result against a typed row or a model.
// Depends on tccw_pkg and text_console_character_writer.
`timescale 1ns / 100ps

module tb_text_console_character_writer;
   import tccw_pkg::*;

   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam logic [VALUE_WIDTH-1:0] BLANK_CELL = {CELL_ATTRIBUTE, SPACE_CHAR};
   localparam int RANDOM_ITEMS   = 625;
   localparam int IDLE_LIMIT     = 20000;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AFTER     = 400;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]  value;
      logic [COLUMN_WIDTH-1:0] column;
      logic [ROW_WIDTH-1:0]    row;
      logic                    cleared;
   } console_rsp_type;

   typedef struct {
      func_type               func;
      logic [CHAR_WIDTH-1:0]  ch;
      logic [INDEX_WIDTH-1:0] index;
      int                     reps;
      bit                     typed;
      console_rsp_type        rsp;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [FUNC_WIDTH-1:0]   req_func = FUNC_PUT;
   logic [CHAR_WIDTH-1:0]   req_character = '0;
   logic [INDEX_WIDTH-1:0]  req_cell_index = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [VALUE_WIDTH-1:0]  rsp_cell_value;
   logic [COLUMN_WIDTH-1:0] rsp_cursor_column;
   logic [ROW_WIDTH-1:0]    rsp_cursor_row;
   logic                    rsp_screen_cleared;

   // Typed expectation travelling with the transaction on offer.
   bit                      offer_typed = 1'b0;
   console_rsp_type         offer_rsp = '0;

   logic [VALUE_WIDTH-1:0]  shadow_screen [0:SCREEN_CELLS-1];
   int unsigned             cursor_col;
   int unsigned             cursor_row;
   console_rsp_type         pending_results [$];
   console_rsp_type         oldest;
   int                      error_count = 0;
   int                      rsp_count = 0;
   int                      idle_cycles = 0;
   bit                      send_calm = 1'b0;
   bit                      recv_calm = 1'b0;
   bit                      hold_done = 1'b0;

   text_console_character_writer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_character      (req_character),
      .req_cell_index     (req_cell_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_screen_cleared (rsp_screen_cleared)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic console_rsp_type predict_console(input func_type f,
                                                       input logic [CHAR_WIDTH-1:0] c,
                                                       input logic [INDEX_WIDTH-1:0] ix);
      console_rsp_type r;
      int unsigned     pos;
      r = '0;
      if (f == FUNC_PUT) begin
         if (c != NULL_CHAR) begin
            if (c == NEWLINE_CHAR) begin
               cursor_row++;
               cursor_col = 0;
            end else begin
               pos = cursor_row * SCREEN_COLUMNS + cursor_col;
               if (pos < SCREEN_CELLS)
                  shadow_screen[pos] = {shadow_screen[pos][15:8], c};
               cursor_col++;
            end
            if (cursor_col >= SCREEN_COLUMNS) begin
               cursor_row++;
               cursor_col = 0;
            end
            if (cursor_row >= SCREEN_ROWS) begin
               for (int i = 0; i < SCREEN_CELLS; i++)
                  shadow_screen[i] = {shadow_screen[i][15:8], SPACE_CHAR};
               cursor_col = 0;
               cursor_row = 0;
               r.cleared = 1'b1;
            end
         end
      end else if (ix < SCREEN_CELLS) begin
         r.value = shadow_screen[ix];
      end
      r.column = cursor_col[COLUMN_WIDTH-1:0];
      r.row    = cursor_row[ROW_WIDTH-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH result %0d %s: got %0h expected %0h", rsp_count, field, got, want);
      error_count++;
   endtask

   // Every accepted request transaction is predicted here.
   always @(posedge clock) begin : track_requests
      console_rsp_type predicted;
      if (!reset && req_valid && req_ready) begin
         predicted = predict_console(func_type'(req_func), req_character, req_cell_index);
         pending_results.push_back(offer_typed ? offer_rsp : predicted);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_cell_value), 0);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_cell_value !== oldest.value)
               report_mismatch("cell_value", 32'(rsp_cell_value), 32'(oldest.value));
            if (rsp_cursor_column !== oldest.column)
               report_mismatch("cursor_column", 32'(rsp_cursor_column), 32'(oldest.column));
            if (rsp_cursor_row !== oldest.row)
               report_mismatch("cursor_row", 32'(rsp_cursor_row), 32'(oldest.row));
            if (rsp_screen_cleared !== oldest.cleared)
               report_mismatch("screen_cleared", 32'(rsp_screen_cleared),
                               32'(oldest.cleared));
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: per-transaction stall, with one long hold-off that backs up the block.
   initial begin : drain_results
      int gap;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0)
            recv_calm = !recv_calm;
         if (!hold_done && rsp_count >= HOLD_AFTER) begin
            gap = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            gap = recv_calm ? 0 : $urandom_range(0, 12);
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_item(input func_type f, input logic [CHAR_WIDTH-1:0] c,
                            input logic [INDEX_WIDTH-1:0] ix, input bit typed,
                            input console_rsp_type typed_rsp);
      int gap;
      if ($urandom_range(0, 29) == 0)
         send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_character  <= c;
      req_cell_index <= ix;
      offer_typed    <= typed;
      offer_rsp      <= typed_rsp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   stim_row_type directed [] = '{
      '{FUNC_READ, 8'h00, 11'd0,    1,  1'b1, '{BLANK_CELL, 7'd0, 5'd0, 1'b0}},
      '{FUNC_READ, 8'h00, 11'd1999, 1,  1'b1, '{BLANK_CELL, 7'd0, 5'd0, 1'b0}},
      '{FUNC_READ, 8'h00, 11'd2000, 1,  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
      '{FUNC_READ, 8'hFF, 11'd2047, 1,  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
      '{FUNC_PUT,  8'h00, 11'd2047, 1,  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
      '{FUNC_PUT,  8'h41, 11'd0,    1,  1'b1, '{16'h0000, 7'd1, 5'd0, 1'b0}},
      '{FUNC_READ, 8'h00, 11'd0,    1,  1'b1, '{16'h0741, 7'd1, 5'd0, 1'b0}},
      '{FUNC_PUT,  8'hFF, 11'd0,    1,  1'b1, '{16'h0000, 7'd2, 5'd0, 1'b0}},
      '{FUNC_PUT,  8'h0A, 11'd0,    1,  1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
      '{FUNC_READ, 8'h00, 11'd1,    1,  1'b1, '{16'h07FF, 7'd0, 5'd1, 1'b0}},
      '{FUNC_PUT,  8'h01, 11'd0,    1,  1'b0, '0},
      '{FUNC_PUT,  8'h80, 11'd0,    1,  1'b0, '0},
      '{FUNC_PUT,  8'h7F, 11'd0,    1,  1'b0, '0},
      '{FUNC_PUT,  8'h0A, 11'd0,    22, 1'b0, '0},
      '{FUNC_PUT,  8'h55, 11'd0,    80, 1'b0, '0},
      '{FUNC_READ, 8'h00, 11'd1919, 1,  1'b1, '{16'h0755, 7'd0, 5'd24, 1'b0}},
      '{FUNC_PUT,  8'h5A, 11'd0,    79, 1'b0, '0},
      '{FUNC_PUT,  8'h5A, 11'd0,    1,  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b1}},
      '{FUNC_READ, 8'h00, 11'd1919, 1,  1'b1, '{BLANK_CELL, 7'd0, 5'd0, 1'b0}},
      '{FUNC_READ, 8'h00, 11'd0,    1,  1'b1, '{BLANK_CELL, 7'd0, 5'd0, 1'b0}},
      '{FUNC_PUT,  8'h0A, 11'd0,    24, 1'b0, '0},
      '{FUNC_PUT,  8'h0A, 11'd0,    1,  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b1}},
      '{FUNC_PUT,  8'h00, 11'd0,    1,  1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
      '{FUNC_READ, 8'h00, 11'd1999, 1,  1'b0, '0},
      '{FUNC_PUT,  8'h20, 11'd0,    1,  1'b0, '0}
   };

   initial begin : stimulus
      int                     sent;
      int                     kind;
      int                     run;
      logic [CHAR_WIDTH-1:0]  c;
      logic [INDEX_WIDTH-1:0] ix;
      for (int i = 0; i < SCREEN_CELLS; i++)
         shadow_screen[i] = BLANK_CELL;
      cursor_col = 0;
      cursor_row = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[r])
         repeat (directed[r].reps)
            send_item(directed[r].func, directed[r].ch, directed[r].index,
                      directed[r].typed, directed[r].rsp);

      // Mostly text lines and reads around the cursor, with nulls and stray indexes.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            send_item(FUNC_PUT, CHAR_WIDTH'($urandom_range(0, 255)),
                      INDEX_WIDTH'($urandom_range(0, 2047)), 1'b0, '0);
            sent++;
         end else if (kind < 62) begin
            send_item(FUNC_PUT, NEWLINE_CHAR, INDEX_WIDTH'($urandom_range(0, 2047)),
                      1'b0, '0);
            sent++;
         end else if (kind < 65) begin
            send_item(FUNC_PUT, NULL_CHAR, INDEX_WIDTH'($urandom_range(0, 2047)),
                      1'b0, '0);
            sent++;
         end else if (kind < 70) begin
            run = $urandom_range(20, 90);
            repeat (run) begin
               c = CHAR_WIDTH'($urandom_range(1, 255));
               if (c == NEWLINE_CHAR)
                  c = SPACE_CHAR;
               send_item(FUNC_PUT, c, INDEX_WIDTH'($urandom_range(0, 2047)), 1'b0, '0);
            end
            sent += run;
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
               ix = INDEX_WIDTH'(cursor_row * SCREEN_COLUMNS
                                 + $urandom_range(0, SCREEN_COLUMNS - 1));
            else if (kind < 85)
               ix = INDEX_WIDTH'($urandom_range(0, SCREEN_CELLS - 1));
            else
               ix = INDEX_WIDTH'($urandom_range(0, 2047));
            send_item(FUNC_READ, CHAR_WIDTH'($urandom_range(0, 255)), ix, 1'b0, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
